// ===== rtl/core/rgb_to_nv12_converter_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef RGB_TO_NV12_CONVERTER_MACROS_SVH
`define RGB_TO_NV12_CONVERTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define R2NV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define R2NV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/r2nv_pkg.sv =====
// Shared types, sizes and colour coefficients for the RGB to NV12 converter.
package r2nv_pkg;

	// Largest frame the counters and line store are built for
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// Size registers and counters
	localparam int SIZE_W     = 13;
	localparam int CMP_W      = SIZE_W + 1;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WIDTH_TOP  = MAX_WIDTH - (MAX_WIDTH % 2);
	localparam int HEIGHT_TOP = MAX_HEIGHT - (MAX_HEIGHT % 2);

	// Line store: one entry per column pair
	localparam int STORE_DEPTH = MAX_WIDTH / 2;
	localparam int SLOT_W      = COL_W - 1;
	localparam int SUM_W       = 9;
	localparam int ENTRY_W     = 2 * SUM_W;

	// Plane indices
	localparam int LUMA_IDX_W   = 24;
	localparam int CHROMA_IDX_W = 22;

	// Register indices of the write port
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

	// Plane kinds on the result channel
	localparam logic KIND_LUMA   = 1'b0;
	localparam logic KIND_CHROMA = 1'b1;

	// BT.601 studio swing coefficients, 16 fractional bits, mod 2^24 arithmetic
	localparam int COEF_W = 24;
	localparam logic [COEF_W-1:0] Y_R   = 24'd16843;
	localparam logic [COEF_W-1:0] Y_G   = 24'd33030;
	localparam logic [COEF_W-1:0] Y_B   = 24'd6423;
	localparam logic [COEF_W-1:0] Y_OFS = 24'd16 << 16;
	localparam logic [COEF_W-1:0] CB_R  = 24'd9699;
	localparam logic [COEF_W-1:0] CB_G  = 24'd19071;
	localparam logic [COEF_W-1:0] CB_B  = 24'd28770;
	localparam logic [COEF_W-1:0] CR_R  = 24'd28770;
	localparam logic [COEF_W-1:0] CR_G  = 24'd24117;
	localparam logic [COEF_W-1:0] CR_B  = 24'd4653;
	localparam logic [COEF_W-1:0] C_OFS = 24'd128 << 16;

	// Raster position of one pixel as it travels down the pipeline
	typedef struct packed {
		logic                    col_odd;
		logic                    row_odd;
		logic [SLOT_W-1:0]       slot;
		logic [LUMA_IDX_W-1:0]   luma_idx;
		logic [CHROMA_IDX_W-1:0] chroma_idx;
	} pix_ctl_t;

endpackage

// ===== rtl/core/r2nv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module r2nv_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/r2nv_ctrl.sv =====
// Frame size registers and raster counters that place each accepted pixel.
module r2nv_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic                     cfg_index,
	input  logic [r2nv_pkg::SIZE_W-1:0] cfg_data,
	input  logic                     accept,
	input  logic                     start_of_frame,
	output r2nv_pkg::pix_ctl_t       ctl
);
	import r2nv_pkg::*;

	logic [SIZE_W-1:0]       frame_width_q, frame_height_q;
	logic [SIZE_W-1:0]       w_use, h_use;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [LUMA_IDX_W-1:0]   luma_q;
	logic [CHROMA_IDX_W-1:0] chroma_q;

	logic [CMP_W-1:0]        cur_c, cur_r, nxt_c, nxt_r;
	logic [LUMA_IDX_W-1:0]   cur_li, nxt_li;
	logic [CHROMA_IDX_W-1:0] cur_ci, nxt_ci;

	// Size registers, bit 0 dropped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RESET_WIDTH;
			frame_height_q <= RESET_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= {cfg_data[SIZE_W-1:1], 1'b0};
				REG_FRAME_HEIGHT: frame_height_q <= {cfg_data[SIZE_W-1:1], 1'b0};
				default:          ;
			endcase
		end
	end

	// Sizes in use, held to 2..max
	always_comb begin
		if (frame_width_q < SIZE_W'(2)) begin
			w_use = SIZE_W'(2);
		end else if (int'(frame_width_q) > WIDTH_TOP) begin
			w_use = SIZE_W'(WIDTH_TOP);
		end else begin
			w_use = frame_width_q;
		end
		if (frame_height_q < SIZE_W'(2)) begin
			h_use = SIZE_W'(2);
		end else if (int'(frame_height_q) > HEIGHT_TOP) begin
			h_use = SIZE_W'(HEIGHT_TOP);
		end else begin
			h_use = frame_height_q;
		end
	end

	// Position of this pixel, then the position of the next one
	always_comb begin
		cur_c  = CMP_W'(col_q);
		cur_r  = CMP_W'(row_q);
		cur_li = luma_q;
		cur_ci = chroma_q;
		if (start_of_frame) begin
			cur_c  = '0;
			cur_r  = '0;
			cur_li = '0;
			cur_ci = '0;
		end
		// counters left beyond a smaller size
		if (cur_c >= CMP_W'(w_use)) begin
			cur_c = '0;
			cur_r = cur_r + CMP_W'(1);
		end
		if (cur_r >= CMP_W'(h_use)) begin
			cur_c  = '0;
			cur_r  = '0;
			cur_li = '0;
			cur_ci = '0;
		end

		nxt_li = cur_li + LUMA_IDX_W'(1);
		nxt_ci = cur_ci + CHROMA_IDX_W'(cur_c[0] & cur_r[0]);
		nxt_c  = cur_c + CMP_W'(1);
		nxt_r  = cur_r;
		if (nxt_c >= CMP_W'(w_use)) begin
			nxt_c = '0;
			nxt_r = cur_r + CMP_W'(1);
			if (nxt_r >= CMP_W'(h_use)) begin
				nxt_r  = '0;
				nxt_li = '0;
				nxt_ci = '0;
			end
		end
	end

	assign ctl.col_odd    = cur_c[0];
	assign ctl.row_odd    = cur_r[0];
	assign ctl.slot       = cur_c[COL_W-1:1];
	assign ctl.luma_idx   = cur_li;
	assign ctl.chroma_idx = cur_ci;

	// Counter update per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			luma_q   <= '0;
			chroma_q <= '0;
		end else if (accept) begin
			col_q    <= nxt_c[COL_W-1:0];
			row_q    <= nxt_r[ROW_W-1:0];
			luma_q   <= nxt_li;
			chroma_q <= nxt_ci;
		end
	end

endmodule

// ===== rtl/core/r2nv_csc.sv =====
// Two-stage colour space conversion: coefficient products, then Y, Cb, Cr.
module r2nv_csc (
	input  logic               clk,
	input  logic               en,
	input  logic [7:0]         blue,
	input  logic [7:0]         green,
	input  logic [7:0]         red,
	input  r2nv_pkg::pix_ctl_t ctl,
	output logic [7:0]         y_s2,
	output logic [7:0]         cb_s2,
	output logic [7:0]         cr_s2,
	output r2nv_pkg::pix_ctl_t ctl_s2
);
	import r2nv_pkg::*;

	logic [COEF_W-1:0] yr_s1, yg_s1, yb_s1;
	logic [COEF_W-1:0] cbr_s1, cbg_s1, cbb_s1;
	logic [COEF_W-1:0] crr_s1, crg_s1, crb_s1;
	pix_ctl_t          ctl_s1;
	logic [COEF_W-1:0] y_sum, cb_sum, cr_sum;

	// Stage 1: the nine products
	always_ff @(posedge clk) begin
		if (en) begin
			yr_s1  <= COEF_W'(red)   * Y_R;
			yg_s1  <= COEF_W'(green) * Y_G;
			yb_s1  <= COEF_W'(blue)  * Y_B;
			cbr_s1 <= COEF_W'(red)   * CB_R;
			cbg_s1 <= COEF_W'(green) * CB_G;
			cbb_s1 <= COEF_W'(blue)  * CB_B;
			crr_s1 <= COEF_W'(red)   * CR_R;
			crg_s1 <= COEF_W'(green) * CR_G;
			crb_s1 <= COEF_W'(blue)  * CR_B;
			ctl_s1 <= ctl;
		end
	end

	// Sums wrap at 24 bits; the integer part sits in bits 23:16
	assign y_sum  = yr_s1 + yg_s1 + yb_s1 + Y_OFS;
	assign cb_sum = C_OFS + cbb_s1 - cbr_s1 - cbg_s1;
	assign cr_sum = C_OFS + crr_s1 - crg_s1 - crb_s1;

	// Stage 2: truncated components
	always_ff @(posedge clk) begin
		if (en) begin
			y_s2   <= y_sum[23:16];
			cb_s2  <= cb_sum[23:16];
			cr_s2  <= cr_sum[23:16];
			ctl_s2 <= ctl_s1;
		end
	end

endmodule

// ===== rtl/core/rgb_to_nv12_converter.sv =====
// Top level of the RGB to NV12 converter: pipeline control, line store and result port.
//
// Pixels enter on the in_valid / in_ready channel in raster order, one BGR
// pixel per beat, with start_of_frame restarting the counters at that pixel.
// Each pixel gives a luma beat (plane_kind 0). The odd column of an odd row
// also gives a chroma beat (plane_kind 1) with the 2x2 averaged Cb and Cr,
// sent right after its luma beat; last_of_run marks the final beat of a pixel.
// Frame sizes are written through cfg_write / cfg_index / cfg_data while idle; the
// user must keep to this, as the block itself has no check for it. A pixel passes
// through the product stage, the sum stage and the output register before its luma
// beat is offered. One pixel per cycle unless in_ready is held low; a pixel
// with a chroma beat holds the single output register until its chroma beat is taken.
// The line store (one entry per column pair) is read and written as the pixel
// leaves the sum stage, so its registered read data lines up with the output register.
// Reset sets 640 x 480, clears counters and pipeline valids; the line store is
// not cleared and needs no clearing pass. When the receiver stalls, the whole
// pipeline holds and in_ready drops until the waiting beat is taken.
module rgb_to_nv12_converter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic                                 cfg_index,
	input  logic [r2nv_pkg::SIZE_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 start_of_frame,
	input  logic [7:0]                           blue,
	input  logic [7:0]                           green,
	input  logic [7:0]                           red,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 plane_kind,
	output logic [r2nv_pkg::LUMA_IDX_W-1:0]      plane_index,
	output logic [7:0]                           first_value,
	output logic [7:0]                           second_value,
	output logic                                 last_of_run
);
	import r2nv_pkg::*;
	`include "rgb_to_nv12_converter_macros.svh"

	pix_ctl_t               in_ctl, ctl_s2;
	logic                   adv, in_accept, last_beat;
	logic                   v1_q, v2_q, v3_q, phase_q;
	logic [7:0]             y_s2, cb_s2, cr_s2;
	logic [15:0]            pending_q;
	logic [SUM_W-1:0]       scb, scr;
	logic                   ram_we, ram_re;
	logic [ENTRY_W-1:0]     ram_rdata;

	logic [7:0]              y_s3;
	logic [LUMA_IDX_W-1:0]   lidx_s3;
	logic [CHROMA_IDX_W-1:0] cidx_s3;
	logic                    chroma_s3;
	logic [SUM_W-1:0]        scb_s3, scr_s3;
	logic [SUM_W:0]          tot_cb, tot_cr;

	// Global advance: the output register is empty or its last beat goes now
	assign last_beat = phase_q | ~chroma_s3;
	assign adv       = ~v3_q | (out_ready & last_beat);
	assign in_ready  = adv;
	assign in_accept = in_valid & in_ready;

	r2nv_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accept         (in_accept),
		.start_of_frame (start_of_frame),
		.ctl            (in_ctl)
	);

	r2nv_csc u_csc (
		.clk    (clk),
		.en     (adv),
		.blue   (blue),
		.green  (green),
		.red    (red),
		.ctl    (in_ctl),
		.y_s2   (y_s2),
		.cb_s2  (cb_s2),
		.cr_s2  (cr_s2),
		.ctl_s2 (ctl_s2)
	);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else if (adv) begin
			v1_q <= in_valid;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	// Column pair sums: even column waits in pending, odd column completes it
	assign scb = SUM_W'(pending_q[7:0])  + SUM_W'(cb_s2);
	assign scr = SUM_W'(pending_q[15:8]) + SUM_W'(cr_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (adv && v2_q && !ctl_s2.col_odd) begin
			pending_q <= {cr_s2, cb_s2};
		end
	end

	// Line store: even rows write pair sums, odd rows read them back
	assign ram_we = adv & v2_q & ctl_s2.col_odd & ~ctl_s2.row_odd;
	assign ram_re = adv & v2_q & ctl_s2.col_odd & ctl_s2.row_odd;

	r2nv_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ctl_s2.slot),
		.wdata ({scr, scb}),
		.re    (ram_re),
		.raddr (ctl_s2.slot),
		.rdata (ram_rdata)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			y_s3      <= y_s2;
			lidx_s3   <= ctl_s2.luma_idx;
			cidx_s3   <= ctl_s2.chroma_idx;
			chroma_s3 <= ctl_s2.col_odd & ctl_s2.row_odd;
			scb_s3    <= scb;
			scr_s3    <= scr;
		end
	end

	// Beat select: luma first, then the chroma beat of the same pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (adv) begin
			phase_q <= 1'b0;
		end else if (v3_q && out_ready) begin
			phase_q <= 1'b1;
		end
	end

	// Four-value chroma totals, floor of a quarter
	assign tot_cb = (SUM_W + 1)'(ram_rdata[SUM_W-1:0])       + (SUM_W + 1)'(scb_s3);
	assign tot_cr = (SUM_W + 1)'(ram_rdata[ENTRY_W-1:SUM_W]) + (SUM_W + 1)'(scr_s3);

	assign out_valid    = v3_q;
	assign plane_kind   = phase_q ? KIND_CHROMA : KIND_LUMA;
	assign plane_index  = phase_q ? LUMA_IDX_W'(cidx_s3) : lidx_s3;
	assign first_value  = phase_q ? tot_cb[SUM_W:2] : y_s3;
	assign second_value = phase_q ? tot_cr[SUM_W:2] : 8'd0;
	assign last_of_run  = last_beat;

	// Checks
	`R2NV_ASSERT_NOW(a_store_one_port, ram_we, !ram_re, "line store read and write together")
	`R2NV_ASSERT_NEXT(a_chroma_follows, out_valid && out_ready && !last_of_run,
		out_valid && plane_kind == KIND_CHROMA, "chroma beat does not follow its luma beat")
	`R2NV_ASSERT_NOW(a_stall_holds, v3_q && !out_ready, !in_ready, "input taken while output stalls")

endmodule

// ===== sim/nv12_output_check.sv =====
// Result monitor for the RGB to NV12 converter: predicts every output beat and compares it.
`timescale 1ns / 100ps

module nv12_output_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic                            cfg_index,
	input  logic [r2nv_pkg::SIZE_W-1:0]     cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            start_of_frame,
	input  logic [7:0]                      blue,
	input  logic [7:0]                      green,
	input  logic [7:0]                      red,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            plane_kind,
	input  logic [r2nv_pkg::LUMA_IDX_W-1:0] plane_index,
	input  logic [7:0]                      first_value,
	input  logic [7:0]                      second_value,
	input  logic                            last_of_run,
	output int                              mismatches,
	output int                              beats_due
);
	import r2nv_pkg::*;

	typedef struct packed {
		logic                  kind;
		logic [LUMA_IDX_W-1:0] index;
		logic [7:0]            first;
		logic [7:0]            second;
		logic                  last;
	} nv12_beat_t;

	// Shadow of the block: size registers, raster position, indices, chroma sums
	logic [SIZE_W-1:0]       width_reg;
	logic [SIZE_W-1:0]       height_reg;
	logic [12:0]             col_pos;
	logic [12:0]             row_pos;
	logic [LUMA_IDX_W-1:0]   luma_idx;
	logic [CHROMA_IDX_W-1:0] chroma_idx;
	logic [15:0]             pair_pending;
	logic [ENTRY_W-1:0]      pair_sums [STORE_DEPTH];

	nv12_beat_t due_beats[$];
	nv12_beat_t want;

	// Size in use: at least 2, at most the even build limit
	function automatic logic [12:0] held_size(input logic [SIZE_W-1:0] v, input int top);
		if (v < 2)
			return 13'd2;
		if (v > top)
			return 13'(top);
		return 13'(v);
	endfunction

	task automatic restart_raster();
		col_pos = '0;
		row_pos = '0;
		luma_idx = '0;
		chroma_idx = '0;
	endtask

	// One pixel in, its luma beat and possibly a chroma beat out
	task automatic convert_pixel(input logic sof, input logic [7:0] b, g, r);
		logic [12:0] w;
		logic [12:0] h;
		logic [31:0] y_acc;
		int          cb_acc;
		int          cr_acc;
		logic [7:0]  y;
		logic [7:0]  cb;
		logic [7:0]  cr;
		logic [8:0]  sum_cb;
		logic [8:0]  sum_cr;
		logic [9:0]  quad_cb;
		logic [9:0]  quad_cr;
		logic [ENTRY_W-1:0] entry;
		logic [SLOT_W-1:0]  slot;
		logic        with_chroma;
		nv12_beat_t  luma_beat;
		nv12_beat_t  chroma_beat;

		w = held_size(width_reg, MAX_WIDTH);
		h = held_size(height_reg, MAX_HEIGHT);
		with_chroma = 1'b0;
		quad_cb = '0;
		quad_cr = '0;

		if (sof)
			restart_raster();
		// a size write may have left the position beyond the new size
		if (col_pos >= w) begin
			col_pos = '0;
			row_pos = row_pos + 1;
		end
		if (row_pos >= h)
			restart_raster();

		y_acc = 32'd16843 * r + 32'd33030 * g + 32'd6423 * b + (32'd16 << 16);
		cb_acc = -9699 * int'(r) - 19071 * int'(g) + 28770 * int'(b) + (128 << 16);
		cr_acc = 28770 * int'(r) - 24117 * int'(g) - 4653 * int'(b) + (128 << 16);
		y = y_acc[23:16];
		cb = cb_acc[23:16];
		cr = cr_acc[23:16];
		slot = col_pos[SLOT_W:1];

		// even column holds its chroma, odd column sums the pair
		if (!col_pos[0]) begin
			pair_pending = {cr, cb};
		end else begin
			sum_cb = {1'b0, pair_pending[7:0]} + {1'b0, cb};
			sum_cr = {1'b0, pair_pending[15:8]} + {1'b0, cr};
			if (!row_pos[0]) begin
				pair_sums[slot] = {sum_cr, sum_cb};
			end else begin
				entry = pair_sums[slot];
				quad_cb = {1'b0, entry[SUM_W-1:0]} + {1'b0, sum_cb};
				quad_cr = {1'b0, entry[ENTRY_W-1:SUM_W]} + {1'b0, sum_cr};
				with_chroma = 1'b1;
			end
		end

		luma_beat.kind = KIND_LUMA;
		luma_beat.index = luma_idx;
		luma_beat.first = y;
		luma_beat.second = 8'd0;
		luma_beat.last = !with_chroma;
		due_beats = {due_beats, luma_beat};
		if (with_chroma) begin
			chroma_beat.kind = KIND_CHROMA;
			chroma_beat.index = LUMA_IDX_W'(chroma_idx);
			chroma_beat.first = quad_cb[9:2];
			chroma_beat.second = quad_cr[9:2];
			chroma_beat.last = 1'b1;
			due_beats = {due_beats, chroma_beat};
			chroma_idx = chroma_idx + 1;
		end

		// advance the raster, wrapping row and frame
		luma_idx = luma_idx + 1;
		col_pos = col_pos + 1;
		if (col_pos >= w) begin
			col_pos = '0;
			row_pos = row_pos + 1;
			if (row_pos >= h)
				restart_raster();
		end
	endtask

	task automatic compare_field(input string name, input logic [LUMA_IDX_W-1:0] exp_v,
			input logic [LUMA_IDX_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
			mismatches++;
		end
	endtask

	// Follow configuration writes, pixel beats and result beats on each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			restart_raster();
			pair_pending = '0;
			due_beats.delete();
			mismatches = 0;
			beats_due = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_data & ~SIZE_W'(1);
				else
					height_reg = cfg_data & ~SIZE_W'(1);
			end
			if (in_valid && in_ready)
				convert_pixel(start_of_frame, blue, green, red);
			if (out_valid && out_ready) begin
				if (due_beats.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual kind %0h index %0h",
						$time, plane_kind, plane_index);
					mismatches++;
				end else begin
					want = due_beats.pop_front();
					compare_field("plane_kind", LUMA_IDX_W'(want.kind), LUMA_IDX_W'(plane_kind));
					compare_field("plane_index", want.index, plane_index);
					compare_field("first_value", LUMA_IDX_W'(want.first), LUMA_IDX_W'(first_value));
					compare_field("second_value", LUMA_IDX_W'(want.second),
						LUMA_IDX_W'(second_value));
					compare_field("last_of_run", LUMA_IDX_W'(want.last), LUMA_IDX_W'(last_of_run));
				end
			end
			beats_due = due_beats.size();
		end
	end

endmodule

// ===== sim/rgb_to_nv12_converter_test.sv =====
// Testbench top for the RGB to NV12 converter: pixel stimulus, result sink and verdict.
`timescale 1ns / 100ps

module rgb_to_nv12_converter_test;
	import r2nv_pkg::*;

	localparam int RANDOM_PIXELS = 1500;
	localparam int LONG_HOLD     = 300;
	localparam int LIMIT_NS      = 1000000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic                  cfg_index;
	logic [SIZE_W-1:0]     cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  start_of_frame;
	logic [7:0]            blue;
	logic [7:0]            green;
	logic [7:0]            red;
	logic                  out_valid;
	logic                  out_ready;
	logic                  plane_kind;
	logic [LUMA_IDX_W-1:0] plane_index;
	logic [7:0]            first_value;
	logic [7:0]            second_value;
	logic                  last_of_run;
	int                    mismatches;
	int                    beats_due;

	// Idling controls shared between the pixel source and the result sink
	bit source_steady;
	bit sink_steady;
	int holds_asked;
	int pixels_sent;

	// Raster position as the block will see it, to keep line store reads on written slots
	int trk_col;
	int trk_row;
	int trk_w;
	int trk_h;
	bit slot_written [STORE_DEPTH];

	rgb_to_nv12_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_of_frame(start_of_frame),
		.blue          (blue),
		.green         (green),
		.red           (red),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.plane_kind    (plane_kind),
		.plane_index   (plane_index),
		.first_value   (first_value),
		.second_value  (second_value),
		.last_of_run   (last_of_run)
	);

	nv12_output_check result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_of_frame(start_of_frame),
		.blue          (blue),
		.green         (green),
		.red           (red),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.plane_kind    (plane_kind),
		.plane_index   (plane_index),
		.first_value   (first_value),
		.second_value  (second_value),
		.last_of_run   (last_of_run),
		.mismatches    (mismatches),
		.beats_due     (beats_due)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Hard stop
	initial begin
		#(LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

	// Result sink: random hold-off per beat, one long hold when asked
	initial begin : result_sink
		int wait_cycles;
		int holds_taken;
		out_ready = 1'b0;
		holds_taken = 0;
		@(posedge arst_n);
		forever begin
			wait_cycles = sink_steady ? 0 : $urandom_range(0, 5);
			if (holds_asked != holds_taken) begin
				wait_cycles = LONG_HOLD;
				holds_taken++;
			end
			if (wait_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	function automatic int held(input int v, input int top);
		if (v < 2)
			return 2;
		if (v > top)
			return top;
		return v;
	endfunction

	// Would the next pixel, without a frame start, average against a slot never written?
	function automatic bit chroma_from_blank_slot();
		int c;
		int r;
		c = trk_col;
		r = trk_row;
		if (c >= trk_w) begin
			c = 0;
			r++;
		end
		if (r >= trk_h) begin
			c = 0;
			r = 0;
		end
		return (c % 2 == 1) && (r % 2 == 1) && !slot_written[c / 2];
	endfunction

	task automatic track_pixel(input bit sof);
		if (sof) begin
			trk_col = 0;
			trk_row = 0;
		end
		if (trk_col >= trk_w) begin
			trk_col = 0;
			trk_row++;
		end
		if (trk_row >= trk_h) begin
			trk_col = 0;
			trk_row = 0;
		end
		if (trk_col % 2 == 1 && trk_row % 2 == 0)
			slot_written[trk_col / 2] = 1'b1;
		trk_col++;
		if (trk_col >= trk_w) begin
			trk_col = 0;
			trk_row++;
			if (trk_row >= trk_h)
				trk_row = 0;
		end
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one pixel beat and hold it until taken
	task automatic send_pixel(input bit want_sof, input logic [7:0] b, g, r);
		int gap;
		bit sof;
		sof = want_sof || chroma_from_blank_slot();
		gap = source_steady ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		start_of_frame <= sof;
		blue <= b;
		green <= g;
		red <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_pixel(sof);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Both size registers, back to back
	task automatic set_frame_size(input logic [SIZE_W-1:0] wv, input logic [SIZE_W-1:0] hv);
		cfg_write <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= wv;
		@(negedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= hv;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		trk_w = held(int'(wv) & 'h1ffe, MAX_WIDTH);
		trk_h = held(int'(hv) & 'h1ffe, MAX_HEIGHT);
	endtask

	// Source pauses until every predicted beat has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (beats_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Main stimulus
	initial begin : pixel_source
		logic [SIZE_W-1:0] wv;
		logic [SIZE_W-1:0] hv;
		int                n;
		int                phase;
		bit                first_sof;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		start_of_frame = 1'b0;
		blue = '0;
		green = '0;
		red = '0;
		source_steady = 1'b0;
		sink_steady = 1'b0;
		holds_asked = 0;
		pixels_sent = 0;
		trk_col = 0;
		trk_row = 0;
		trk_w = int'(RESET_WIDTH);
		trk_h = int'(RESET_HEIGHT);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a few pixels at the reset size, then colour corners in a 4 x 4 frame
		// entered without a frame start, so the old column lies beyond the new width
		send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
		send_pixel(1'b0, 8'hff, 8'hff, 8'hff);
		send_pixel(1'b0, 8'hff, 8'h00, 8'h00);
		send_pixel(1'b0, 8'h00, 8'hff, 8'h00);
		drain_results();
		set_frame_size(13'd4, 13'd4);
		for (int k = 0; k < 16; k++)
			send_pixel(1'b0, k[0] ? 8'hff : 8'h00, k[1] ? 8'hff : 8'h00, k[2] ? 8'hff : 8'h00);

		// Random phases, each at a size written while idle
		phase = 0;
		while (pixels_sent < 20 + RANDOM_PIXELS) begin
			drain_results();
			n = $urandom_range(20, 120);
			case ($urandom_range(0, 11))
				0: begin
					wv = SIZE_W'($urandom_range(0, 1));
					hv = SIZE_W'($urandom_range(0, 3));
				end
				1: begin
					wv = ($urandom_range(0, 1) != 0) ? 13'h1fff : 13'd4097;
					hv = SIZE_W'($urandom_range(2, 4));
					n = 150;
				end
				2: begin
					wv = SIZE_W'($urandom_range(2, 3));
					hv = ($urandom_range(0, 1) != 0) ? 13'h1fff : 13'd4096;
					n = 200;
				end
				default: begin
					wv = SIZE_W'($urandom_range(2, 16));
					hv = SIZE_W'($urandom_range(2, 8));
				end
			endcase
			set_frame_size(wv, hv);
			source_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			// one phase with a long sink hold while the source keeps offering
			if (phase == 2) begin
				source_steady = 1'b1;
				sink_steady = 1'b0;
				holds_asked++;
				n = 250;
			end
			first_sof = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < n; i++)
				send_pixel((i == 0 && first_sof) || ($urandom_range(0, 63) == 0),
					pick_level(), pick_level(), pick_level());
			phase++;
		end

		drain_results();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && beats_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
